// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the area rotate index design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked every clock while reset is released.
`define ARI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked every clock, reset included.
`define ARI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARI_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/ari_pkg.sv
// ----------------------------------------------------------------------------
// ari_pkg
// Widths, defaults, rotation codes and stage payload types of the area
// rotate index.
// ----------------------------------------------------------------------------
package ari_pkg;

    localparam int CW     = 10;
    localparam int PIX_W  = 16;
    localparam int OFF_W  = 15;
    localparam int SIZE_W = 11;
    localparam int ROT_W  = 2;
    localparam int IDX_W  = 2 * CW;

    localparam int IN_BITS     = 4 * CW + PIX_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = PIX_W + OFF_W + 2 * CW + 2 * SIZE_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int unsigned PANEL_WIDTH_DEF   = 480;
    localparam int unsigned PANEL_HEIGHT_DEF  = 480;
    localparam int unsigned BUFFER_PIXELS_DEF = 32768;

    typedef enum logic [ROT_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             first;
        logic [CW-1:0]    y2;
        logic [CW-1:0]    x2;
        logic [CW-1:0]    y1;
        logic [CW-1:0]    x1;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        t_rot             rot;
        logic [CW-1:0]    left;
        logic [CW-1:0]    top;
        logic [CW-1:0]    right;
        logic [CW-1:0]    bottom;
        logic [CW-1:0]    dx;
        logic [CW-1:0]    dy;
        logic [CW-1:0]    col;
        logic [CW-1:0]    row;
        logic             last;
    } t_trk;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [IDX_W-1:0]  off;
        logic [CW-1:0]     nx;
        logic [CW-1:0]     ny;
        logic [SIZE_W-1:0] nw;
        logic [SIZE_W-1:0] nh;
        logic              last;
    } t_map;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [OFF_W-1:0]  dest_offset;
        logic [CW-1:0]     nx;
        logic [CW-1:0]     ny;
        logic [SIZE_W-1:0] nw;
        logic [SIZE_W-1:0] nh;
        logic              last;
    } t_res;

endpackage

// File: design/area_rotate_index.sv
// ----------------------------------------------------------------------------
// area_rotate_index
// Pixel stream to rotated buffer index: origin, size and offset per pixel.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while the output is not stalled and gives one
// result beat per pixel. The pixel path is a four-register pipeline: position
// tracking, the offset multiply, the reciprocal quotient estimate, and the
// remainder correction into the output register. A beat with tuser set starts a
// new area, latching its corners from tdata. The rotation register is written
// through i_cfg_we and should only change while no pixel is in flight.
`include "assert_macros.svh"

module area_rotate_index #(
    parameter int unsigned PANEL_WIDTH   = ari_pkg::PANEL_WIDTH_DEF,
    parameter int unsigned PANEL_HEIGHT  = ari_pkg::PANEL_HEIGHT_DEF,
    parameter int unsigned BUFFER_PIXELS = ari_pkg::BUFFER_PIXELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ari_pkg::ROT_W-1:0]         i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // area_x1, area_y1, area_x2, area_y2, pixel_in
    input  logic [ari_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // first_pixel
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_out, dest_offset, native_x0, native_y0, native_w, native_h
    output logic [ari_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int CW = ari_pkg::CW;

    ari_pkg::t_rot    r_rot;
    ari_pkg::t_pix_in s_item;
    ari_pkg::t_trk    trk_data;
    ari_pkg::t_map    map_data;
    ari_pkg::t_res    res;
    logic             trk_valid, trk_ready, map_valid, map_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= ari_pkg::ROT_0;
        end else if (i_cfg_we) begin
            r_rot <= ari_pkg::t_rot'(i_cfg_wdata);
        end
    end

    assign s_item.x1    = s_axis_tdata[CW-1:0];
    assign s_item.y1    = s_axis_tdata[2*CW-1:CW];
    assign s_item.x2    = s_axis_tdata[3*CW-1:2*CW];
    assign s_item.y2    = s_axis_tdata[4*CW-1:3*CW];
    assign s_item.pixel = s_axis_tdata[4*CW+ari_pkg::PIX_W-1:4*CW];
    assign s_item.first = s_axis_tuser[0];

    ari_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_data  (s_item),
        .i_rot     (r_rot),
        .o_m_valid (trk_valid),
        .i_m_ready (trk_ready),
        .o_m_data  (trk_data)
    );

    ari_map #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (trk_valid),
        .o_s_ready (trk_ready),
        .i_s_data  (trk_data),
        .o_m_valid (map_valid),
        .i_m_ready (map_ready),
        .o_m_data  (map_data)
    );

    ari_reduce #(
        .BUFFER_PIXELS (BUFFER_PIXELS)
    ) u_reduce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (map_valid),
        .o_s_ready (map_ready),
        .i_s_data  (map_data),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (res)
    );

    assign m_axis_tdata = ari_pkg::OUT_TDATA_W'({res.nh, res.nw, res.ny, res.nx,
                                                 res.dest_offset, res.pixel});
    assign m_axis_tlast = res.last;

endmodule

// File: design/ari_track.sv
// ----------------------------------------------------------------------------
// ari_track
// Latches area corners, walks the column and row counters and registers
// each accepted beat with its position in the area.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ari_track (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_valid,
    output logic            o_s_ready,
    input  ari_pkg::t_pix_in i_s_data,
    input  ari_pkg::t_rot   i_rot,
    output logic            o_m_valid,
    input  logic            i_m_ready,
    output ari_pkg::t_trk   o_m_data
);

    logic [ari_pkg::CW-1:0] r_left, r_top, r_right, r_bottom, r_col, r_row;
    logic [ari_pkg::CW-1:0] n_col, n_row;
    logic [ari_pkg::CW-1:0] e_left, e_top, e_right, e_bottom, e_col, e_row;
    logic [ari_pkg::CW-1:0] e_dx, e_dy, held_dx, held_dy;
    logic                   e_last;
    logic                   accept;
    logic                   r_v;
    ari_pkg::t_trk          r_data, n_data;

    assign o_s_ready = !r_v || i_m_ready;
    assign accept    = i_s_valid && o_s_ready;

    always_comb begin
        e_left   = i_s_data.first ? i_s_data.x1 : r_left;
        e_top    = i_s_data.first ? i_s_data.y1 : r_top;
        e_right  = i_s_data.first ? i_s_data.x2 : r_right;
        e_bottom = i_s_data.first ? i_s_data.y2 : r_bottom;
        e_col    = i_s_data.first ? '0 : r_col;
        e_row    = i_s_data.first ? '0 : r_row;
        e_dx     = e_right - e_left;
        e_dy     = e_bottom - e_top;
        e_last   = (e_col == e_dx) && (e_row == e_dy);

        // advance column; wrap to next row, then to the area start
        if (e_col >= e_dx) begin
            n_col = '0;
            n_row = (e_row >= e_dy) ? '0 : e_row + ari_pkg::CW'(1);
        end else begin
            n_col = e_col + ari_pkg::CW'(1);
            n_row = e_row;
        end

        n_data.pixel  = i_s_data.pixel;
        n_data.rot    = i_rot;
        n_data.left   = e_left;
        n_data.top    = e_top;
        n_data.right  = e_right;
        n_data.bottom = e_bottom;
        n_data.dx     = e_dx;
        n_data.dy     = e_dy;
        n_data.col    = e_col;
        n_data.row    = e_row;
        n_data.last   = e_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= 1'b0;
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (o_s_ready) begin
                r_v <= i_s_valid;
            end
            if (accept) begin
                r_left   <= e_left;
                r_top    <= e_top;
                r_right  <= e_right;
                r_bottom <= e_bottom;
                r_col    <= n_col;
                r_row    <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= n_data;
        end
    end

    assign o_m_valid = r_v;
    assign o_m_data  = r_data;

    assign held_dx = r_right - r_left;
    assign held_dy = r_bottom - r_top;

    `ARI_ASSERT(a_pos_in_area, i_clk, i_rst_n, (r_col <= held_dx) && (r_row <= held_dy), "counter outside area")
    `ARI_ASSERT(a_last_wraps, i_clk, i_rst_n, (accept && e_last) |=> (r_col == '0) && (r_row == '0), "no wrap after last beat")

endmodule

// File: design/ari_map.sv
// ----------------------------------------------------------------------------
// ari_map
// Maps a positioned beat to the rotated buffer: native origin, native size
// and the unreduced buffer offset.
// ----------------------------------------------------------------------------
module ari_map #(
    parameter int unsigned PANEL_WIDTH  = ari_pkg::PANEL_WIDTH_DEF,
    parameter int unsigned PANEL_HEIGHT = ari_pkg::PANEL_HEIGHT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  ari_pkg::t_trk i_s_data,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    output ari_pkg::t_map o_m_data
);

    localparam logic [ari_pkg::CW-1:0] PW_M1 = ari_pkg::CW'(PANEL_WIDTH - 1);
    localparam logic [ari_pkg::CW-1:0] PH_M1 = ari_pkg::CW'(PANEL_HEIGHT - 1);

    logic [ari_pkg::SIZE_W-1:0] w, h, m2;
    logic [ari_pkg::CW-1:0]     m1, add, col_rev, row_rev;
    logic                       r_v;
    ari_pkg::t_map              r_data, n_data;

    assign o_s_ready = !r_v || i_m_ready;

    always_comb begin
        w       = ari_pkg::SIZE_W'(i_s_data.dx) + ari_pkg::SIZE_W'(1);
        h       = ari_pkg::SIZE_W'(i_s_data.dy) + ari_pkg::SIZE_W'(1);
        col_rev = i_s_data.dx - i_s_data.col;
        row_rev = i_s_data.dy - i_s_data.row;

        n_data.pixel = i_s_data.pixel;
        n_data.last  = i_s_data.last;
        n_data.nw    = w;
        n_data.nh    = h;
        n_data.nx    = i_s_data.left;
        n_data.ny    = i_s_data.top;
        m1           = i_s_data.row;
        m2           = w;
        add          = i_s_data.col;

        unique case (i_s_data.rot)
            ari_pkg::ROT_0: begin
                m1  = i_s_data.row;
                m2  = w;
                add = i_s_data.col;
            end
            ari_pkg::ROT_90: begin
                n_data.nw = h;
                n_data.nh = w;
                n_data.nx = PW_M1 - i_s_data.bottom;
                n_data.ny = i_s_data.left;
                m1        = i_s_data.col;
                m2        = h;
                add       = row_rev;
            end
            ari_pkg::ROT_180: begin
                n_data.nx = PW_M1 - i_s_data.right;
                n_data.ny = PH_M1 - i_s_data.bottom;
                m1        = row_rev;
                m2        = w;
                add       = col_rev;
            end
            ari_pkg::ROT_270: begin
                n_data.nw = h;
                n_data.nh = w;
                n_data.nx = i_s_data.top;
                n_data.ny = PH_M1 - i_s_data.right;
                m1        = col_rev;
                m2        = h;
                add       = i_s_data.row;
            end
        endcase

        n_data.off = ari_pkg::IDX_W'(m1) * ari_pkg::IDX_W'(m2) + ari_pkg::IDX_W'(add);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_s_ready) begin
            r_v <= i_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_valid && o_s_ready) begin
            r_data <= n_data;
        end
    end

    assign o_m_valid = r_v;
    assign o_m_data  = r_data;

endmodule

// File: design/ari_reduce.sv
// ----------------------------------------------------------------------------
// ari_reduce
// Folds the offset into the buffer size with a reciprocal quotient estimate
// and one correction, then holds the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ari_reduce #(
    parameter int unsigned BUFFER_PIXELS = ari_pkg::BUFFER_PIXELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  ari_pkg::t_map i_s_data,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    output ari_pkg::t_res o_m_data
);

    localparam int unsigned RECIP   = (2 ** ari_pkg::IDX_W) / BUFFER_PIXELS;
    localparam int          RECIP_W = $clog2(RECIP + 1);
    localparam logic [RECIP_W-1:0]       RECIP_K = RECIP_W'(RECIP);
    localparam logic [ari_pkg::IDX_W:0]  BUF_K   = (ari_pkg::IDX_W + 1)'(BUFFER_PIXELS);

    logic [ari_pkg::IDX_W+RECIP_W-1:0] n_prod;
    logic [RECIP_W-1:0]                r_q;
    ari_pkg::t_map                     r_mid;
    logic                              r_v3, r_vo, ready3;
    logic [ari_pkg::IDX_W-1:0]         n_qb, n_rem_raw, n_rem;
    ari_pkg::t_res                     r_out, n_out;

    assign o_s_ready = !r_v3 || ready3;
    assign ready3    = !r_vo || i_m_ready;

    assign n_prod = i_s_data.off * RECIP_K;

    always_comb begin
        n_qb      = ari_pkg::IDX_W'(r_q * BUF_K);
        n_rem_raw = r_mid.off - n_qb;
        n_rem     = ({1'b0, n_rem_raw} >= BUF_K)
                  ? ari_pkg::IDX_W'({1'b0, n_rem_raw} - BUF_K) : n_rem_raw;

        n_out.pixel       = r_mid.pixel;
        n_out.dest_offset = n_rem[ari_pkg::OFF_W-1:0];
        n_out.nx          = r_mid.nx;
        n_out.ny          = r_mid.ny;
        n_out.nw          = r_mid.nw;
        n_out.nh          = r_mid.nh;
        n_out.last        = r_mid.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (o_s_ready) begin
                r_v3 <= i_s_valid;
            end
            if (ready3) begin
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_valid && o_s_ready) begin
            r_mid <= i_s_data;
            r_q   <= n_prod[ari_pkg::IDX_W+RECIP_W-1:ari_pkg::IDX_W];
        end
        if (r_v3 && ready3) begin
            r_out <= n_out;
        end
    end

    assign o_m_valid = r_vo;
    assign o_m_data  = r_out;

    `ARI_ASSERT(a_rem_below_buf, i_clk, i_rst_n, r_v3 |-> ({1'b0, n_rem} < BUF_K), "offset not reduced")

endmodule

// File: tb/area_rotate_index_tb.sv
// ----------------------------------------------------------------------------
// area_rotate_index_tb
// Streams logical pixel areas through the rotate index block under all four
// rotations and checks each output beat against a local model of the position
// counters, native origin and size and rotated offset, or a fixed typed beat.
// ----------------------------------------------------------------------------
module area_rotate_index_tb;

    localparam int unsigned PANEL_W = ari_pkg::PANEL_WIDTH_DEF;
    localparam int unsigned PANEL_H = ari_pkg::PANEL_HEIGHT_DEF;
    localparam int unsigned BUF_PIX = ari_pkg::BUFFER_PIXELS_DEF;

    typedef struct {
        ari_pkg::t_rot rot;
        logic [9:0]    x1;
        logic [9:0]    y1;
        logic [9:0]    x2;
        logic [9:0]    y2;
        logic          first;
        logic [15:0]   pixel;
        bit            typed;
        ari_pkg::t_res want;
    } t_dir_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [ari_pkg::ROT_W-1:0]       i_cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // area_x1, area_y1, area_x2, area_y2, pixel_in
    logic [ari_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    // first_pixel
    logic [0:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // pixel_out, dest_offset, native_x0, native_y0, native_w, native_h
    logic [ari_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;

    int            src_idle_pct;
    int            sink_idle_pct;
    int            errors = 0;
    bit            want_typed;
    ari_pkg::t_res want_fixed;
    ari_pkg::t_res mapped_pixels_q[$];
    t_dir_row      dir_rows[$];
    ari_pkg::t_rot cur_rot;

    // model state
    ari_pkg::t_rot rot_q = ari_pkg::ROT_0;
    logic [9:0] pos_col = '0;
    logic [9:0] pos_row = '0;
    logic [9:0] area_left = '0;
    logic [9:0] area_top = '0;
    logic [9:0] area_right = '0;
    logic [9:0] area_bottom = '0;

    area_rotate_index dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic ari_pkg::t_res locate_pixel(input logic [9:0] x1, input logic [9:0] y1,
                                                   input logic [9:0] x2, input logic [9:0] y2,
                                                   input logic first,
                                                   input logic [15:0] pixel);
        int unsigned   w, h, c, r, nx, ny, nw, nh, off;
        logic [9:0]    span_x, span_y;
        ari_pkg::t_res res;
        if (first) begin
            area_left   = x1;
            area_top    = y1;
            area_right  = x2;
            area_bottom = y2;
            pos_col     = '0;
            pos_row     = '0;
        end
        span_x = area_right - area_left;
        span_y = area_bottom - area_top;
        w = span_x + 1;
        h = span_y + 1;
        c = pos_col;
        r = pos_row;
        case (rot_q)
            ari_pkg::ROT_90: begin
                nw = h; nh = w;
                nx = PANEL_W - 1 - area_bottom;
                ny = area_left;
                off = c * nw + (h - 1 - r);
            end
            ari_pkg::ROT_180: begin
                nw = w; nh = h;
                nx = PANEL_W - 1 - area_right;
                ny = PANEL_H - 1 - area_bottom;
                off = (h - 1 - r) * nw + (w - 1 - c);
            end
            ari_pkg::ROT_270: begin
                nw = h; nh = w;
                nx = area_top;
                ny = PANEL_H - 1 - area_right;
                off = (w - 1 - c) * nw + r;
            end
            default: begin
                nw = w; nh = h;
                nx = area_left;
                ny = area_top;
                off = r * nw + c;
            end
        endcase
        off = off % BUF_PIX;
        res.pixel       = pixel;
        res.dest_offset = off[ari_pkg::OFF_W-1:0];
        res.nx          = nx[ari_pkg::CW-1:0];
        res.ny          = ny[ari_pkg::CW-1:0];
        res.nw          = nw[ari_pkg::SIZE_W-1:0];
        res.nh          = nh[ari_pkg::SIZE_W-1:0];
        res.last        = (c == w - 1) && (r == h - 1);
        if (c >= w - 1) begin
            pos_col = '0;
            pos_row = (r >= h - 1) ? 10'd0 : 10'(r + 1);
        end else begin
            pos_col = 10'(c + 1);
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        ari_pkg::t_res pred;
        ari_pkg::t_res want;
        if (i_rst_n) begin
            if (i_cfg_we)
                rot_q = ari_pkg::t_rot'(i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready) begin
                pred = locate_pixel(s_axis_tdata[9:0], s_axis_tdata[19:10],
                                    s_axis_tdata[29:20], s_axis_tdata[39:30],
                                    s_axis_tuser[0], s_axis_tdata[55:40]);
                mapped_pixels_q.push_back(want_typed ? want_fixed : pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (mapped_pixels_q.size() == 0) begin
                    $error("result beat with no pixel pending");
                    errors++;
                end else begin
                    want = mapped_pixels_q.pop_front();
                    check_field("pixel_out", want.pixel, m_axis_tdata[15:0]);
                    check_field("dest_offset", want.dest_offset, m_axis_tdata[30:16]);
                    check_field("native_x0", want.nx, m_axis_tdata[40:31]);
                    check_field("native_y0", want.ny, m_axis_tdata[50:41]);
                    check_field("native_w", want.nw, m_axis_tdata[61:51]);
                    check_field("native_h", want.nh, m_axis_tdata[72:62]);
                    check_field("last_pixel", want.last, m_axis_tlast);
                end
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_pixel(input logic [9:0] x1, input logic [9:0] y1,
                              input logic [9:0] x2, input logic [9:0] y2,
                              input logic first, input logic [15:0] pixel,
                              input bit typed, input ari_pkg::t_res want);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pixel, y2, x2, y1, x1};
        s_axis_tuser  <= first;
        want_typed    <= typed;
        want_fixed    <= want;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (mapped_pixels_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_rotation(input ari_pkg::t_rot r);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_rot = r;
    endtask

    task automatic add_row(input ari_pkg::t_rot rot, input logic [9:0] x1,
                           input logic [9:0] y1, input logic [9:0] x2,
                           input logic [9:0] y2, input logic first,
                           input logic [15:0] pixel, input bit typed,
                           input ari_pkg::t_res want);
        t_dir_row row;
        row.rot   = rot;
        row.x1    = x1;
        row.y1    = y1;
        row.x2    = x2;
        row.y2    = y2;
        row.first = first;
        row.pixel = pixel;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic send_area(input int w, input int h, input int npix);
        logic [9:0] x1, y1;
        x1 = 10'($urandom);
        y1 = 10'($urandom);
        for (int i = 0; i < npix; i++) begin
            if (i == 0)
                send_pixel(x1, y1, 10'(x1 + w - 1), 10'(y1 + h - 1), 1'b1,
                           16'($urandom), 1'b0, '0);
            else
                send_pixel(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                           1'b0, 16'($urandom), 1'b0, '0);
        end
    endtask

    task automatic run_segment(input ari_pkg::t_rot r, input int quota);
        int sent, w, h, n, kind;
        set_rotation(r);
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(99);
            if (kind < 92) begin
                if (kind < 65) begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 6);
                    n = w * h;
                    if ($urandom_range(9) == 0)
                        n += $urandom_range(1, 3);
                end else if (kind < 75) begin
                    w = $urandom_range(1, 48);
                    h = $urandom_range(1, 2);
                    n = w * h;
                end else if (kind < 85) begin
                    w = ($urandom_range(3) == 0) ? 1024 : $urandom_range(1, 1024);
                    h = ($urandom_range(3) == 0) ? 1024 : $urandom_range(1, 1024);
                    n = $urandom_range(1, 24);
                end else begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 6);
                    n = $urandom_range(1, w * h);
                end
                send_area(w, h, n);
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_pixel(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                               1'($urandom), 16'($urandom), 1'b0, '0);
            end
            sent += n;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = ari_pkg::ROT_0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        want_typed    = 1'b0;
        want_fixed    = '0;
        cur_rot       = ari_pkg::ROT_0;
        src_idle_pct  = 26;
        sink_idle_pct = 60;

        add_row(ari_pkg::ROT_0, 0, 0, 0, 0, 1'b0, 16'h0000, 1'b1,
                ari_pkg::t_res'{pixel: 16'h0000, dest_offset: 0, nx: 0, ny: 0, nw: 1,
                                nh: 1, last: 1});
        add_row(ari_pkg::ROT_0, 1023, 1023, 1023, 1023, 1'b0, 16'hFFFF, 1'b1,
                ari_pkg::t_res'{pixel: 16'hFFFF, dest_offset: 0, nx: 0, ny: 0, nw: 1,
                                nh: 1, last: 1});
        add_row(ari_pkg::ROT_0, 0, 0, 1023, 1023, 1'b1, 16'h1234, 1'b1,
                ari_pkg::t_res'{pixel: 16'h1234, dest_offset: 0, nx: 0, ny: 0, nw: 1024,
                                nh: 1024, last: 0});
        add_row(ari_pkg::ROT_0, 1023, 1023, 0, 0, 1'b1, 16'hAAAA, 1'b0, '0);
        add_row(ari_pkg::ROT_0, 0, 0, 0, 0, 1'b0, 16'h5555, 1'b0, '0);
        add_row(ari_pkg::ROT_0, 0, 0, 0, 0, 1'b0, 16'h0F0F, 1'b0, '0);
        add_row(ari_pkg::ROT_0, 0, 0, 0, 0, 1'b0, 16'hF0F0, 1'b0, '0);
        add_row(ari_pkg::ROT_0, 0, 0, 0, 0, 1'b0, 16'h8001, 1'b0, '0);
        add_row(ari_pkg::ROT_90, 1022, 999, 1023, 1000, 1'b1, 16'h0001, 1'b0, '0);
        add_row(ari_pkg::ROT_90, 0, 0, 0, 0, 1'b0, 16'h0002, 1'b0, '0);
        add_row(ari_pkg::ROT_90, 0, 0, 0, 0, 1'b0, 16'h0004, 1'b0, '0);
        add_row(ari_pkg::ROT_90, 0, 0, 0, 0, 1'b0, 16'h0008, 1'b0, '0);
        add_row(ari_pkg::ROT_90, 0, 0, 0, 0, 1'b0, 16'h0010, 1'b0, '0);
        add_row(ari_pkg::ROT_180, 0, 0, 1023, 1023, 1'b1, 16'hFFFF, 1'b1,
                ari_pkg::t_res'{pixel: 16'hFFFF, dest_offset: 32767, nx: 480, ny: 480,
                                nw: 1024, nh: 1024, last: 0});
        add_row(ari_pkg::ROT_180, 3, 4, 5, 4, 1'b1, 16'h0020, 1'b0, '0);
        add_row(ari_pkg::ROT_180, 0, 0, 0, 0, 1'b0, 16'h0040, 1'b0, '0);
        add_row(ari_pkg::ROT_180, 0, 0, 0, 0, 1'b0, 16'h0080, 1'b0, '0);
        add_row(ari_pkg::ROT_270, 1021, 0, 1023, 1, 1'b1, 16'h0100, 1'b0, '0);
        for (int i = 0; i < 5; i++)
            add_row(ari_pkg::ROT_270, 0, 0, 0, 0, 1'b0, 16'h0200 << i, 1'b0, '0);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].rot != cur_rot)
                set_rotation(dir_rows[i].rot);
            send_pixel(dir_rows[i].x1, dir_rows[i].y1, dir_rows[i].x2, dir_rows[i].y2,
                       dir_rows[i].first, dir_rows[i].pixel, dir_rows[i].typed,
                       dir_rows[i].want);
        end

        for (int m = 0; m < 3; m++) begin
            case (m)
                0: begin src_idle_pct = 26; sink_idle_pct = 60; end
                1: begin src_idle_pct = 60; sink_idle_pct = 26; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            for (int seg = 0; seg < 4; seg++)
                run_segment(ari_pkg::t_rot'((seg + m) % 4), 145);
        end

        drain();
        repeat (12) @(posedge i_clk);
        if (errors == 0 && mapped_pixels_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/ari_pkg.sv
design/ari_track.sv
design/ari_map.sv
design/ari_reduce.sv
design/area_rotate_index.sv
tb/area_rotate_index_tb.sv
